// ===== rtl/core/tmcsd_pkg.sv =====
// Shared constants, codes and types for the tile map cell stream decoder.
package tmcsd_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_SIDE_DEF   = 1024;
  localparam int TILE_BITS_DEF  = 24;
  localparam int LAYER_BITS_DEF = 8;
  localparam int QUEUE_DEPTH    = 4;

  // Fixed widths of the byte stream and the register port.
  localparam int BYTE_BITS        = 8;
  localparam int CFG_WIDTH        = 11;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int LAYER_COUNT_BITS = 8;

  // Number system of the map body.
  localparam int DIGIT_BASE   = 253;
  localparam int DIGIT_OFFSET = 3;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LAYER_COUNT = 2'd2;

  // Separator codes.
  localparam logic [1:0] SEP_MAP_END    = 2'd0;
  localparam logic [1:0] SEP_NEXT_ENTRY = 2'd1;
  localparam logic [1:0] SEP_CELL_END   = 2'd2;

  // One classified byte.
  typedef struct packed {
    logic                 is_digit;
    logic [BYTE_BITS-1:0] digit;
    logic [1:0]           sep;
  } token_t;

  // Status of the token queue seen by its neighbors.
  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

// ===== rtl/core/tmcsd_front.sv =====
// Front end: takes map body bytes and classifies them into digit or separator tokens.
module tmcsd_front
  import tmcsd_pkg::*;
(
  input  logic                 in_valid,
  input  logic [BYTE_BITS-1:0] in_byte,
  output logic                 in_ready,
  input  queue_status_t        q_status,
  output logic                 push,
  output token_t               push_token
);

  logic is_digit;

  // Bytes from the offset up are digits; the rest are separators.
  assign is_digit = (in_byte >= BYTE_BITS'(DIGIT_OFFSET));

  assign in_ready = !q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_token.is_digit = is_digit;
    push_token.digit    = is_digit ? (in_byte - BYTE_BITS'(DIGIT_OFFSET)) : '0;
    push_token.sep      = in_byte[1:0];
  end

endmodule

// ===== rtl/core/tmcsd_queue.sv =====
// Short token queue between the classifying front end and the decoding back end.
module tmcsd_queue
  import tmcsd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  token_t        push_token,
  input  logic          pop,
  output token_t        head_token,
  output queue_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  token_t         slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign status.valid = (count != '0);
  assign status.full  = (count == CW'(DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign head_token   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/tmcsd_back.sv =====
// Back end: accumulates numbers, walks the cell grid and registers entry and map end results.
module tmcsd_back
  import tmcsd_pkg::*;
#(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int TILE_BITS  = TILE_BITS_DEF,
  parameter int LAYER_BITS = LAYER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  token_t                      tok,
  input  queue_status_t               q_status,
  output logic                        pop,
  input  logic [$clog2(MAX_SIDE):0]   side_w,
  input  logic [$clog2(MAX_SIDE):0]   side_h,
  input  logic [LAYER_COUNT_BITS-1:0] layer_count,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [$clog2(MAX_SIDE)-1:0] out_col,
  output logic [$clog2(MAX_SIDE)-1:0] out_row,
  output logic [LAYER_BITS-1:0]       out_layer,
  output logic [TILE_BITS-1:0]        out_tile,
  output logic                        out_solid,
  output logic                        out_has_entry,
  output logic                        out_map_done,
  output logic                        out_overflow,
  output logic                        out_bad_layer
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int PW = TILE_BITS + BYTE_BITS;
  localparam int MW = (TILE_BITS > LAYER_BITS) ? TILE_BITS : LAYER_BITS;
  localparam int LW = (LAYER_BITS > LAYER_COUNT_BITS) ? LAYER_BITS : LAYER_COUNT_BITS;

  localparam logic [1:0] PH_CELL  = 2'd0;
  localparam logic [1:0] PH_LAYER = 2'd1;
  localparam logic [1:0] PH_TILE  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  logic [1:0]            phase;
  logic [1:0]            phase_next;
  logic [TILE_BITS-1:0]  acc;
  logic [TILE_BITS-1:0]  acc_next;
  logic [LAYER_BITS-1:0] held;
  logic [LAYER_BITS-1:0] held_next;
  logic                  ovf;
  logic                  ovf_next;
  logic [CW-1:0]         col;
  logic [CW-1:0]         col_next;
  logic [CW-1:0]         row;
  logic [CW-1:0]         row_next;

  logic                  fire;
  logic                  emit;
  logic                  emit_done;
  logic [PW-1:0]         prod;
  logic                  dig_sat;
  logic [TILE_BITS-1:0]  acc_dig;
  logic [MW-1:0]         acc_wide;
  logic [MW-1:0]         lmax_wide;
  logic                  layer_sat;
  logic [LAYER_BITS-1:0] layer_val;
  logic [CW:0]           row_inc;
  logic [CW:0]           col_inc;
  logic                  row_wrap;
  logic                  grid_end;
  logic                  cell_done;

  // A token is consumed whenever the result register is free or being drained.
  assign fire = q_status.valid && (!out_valid || out_ready);
  assign pop  = fire;

  // One digit step: multiply by the base and add, saturating at the tile width.
  assign prod    = PW'(acc) * PW'(DIGIT_BASE) + PW'(tok.digit);
  assign dig_sat = (prod[PW-1:TILE_BITS] != '0);
  assign acc_dig = dig_sat ? '1 : prod[TILE_BITS-1:0];

  // Layer number saturates at its own width when the separator arrives.
  assign acc_wide  = MW'(acc);
  assign lmax_wide = MW'({LAYER_BITS{1'b1}});
  assign layer_sat = (acc_wide > lmax_wide);
  assign layer_val = layer_sat ? '1 : LAYER_BITS'(acc_wide);

  // Row-inner, column-outer walk of the grid.
  assign row_inc   = {1'b0, row} + 1'b1;
  assign col_inc   = {1'b0, col} + 1'b1;
  assign row_wrap  = (row_inc >= side_h);
  assign grid_end  = row_wrap && (col_inc >= side_w);
  assign cell_done = (tok.sep == SEP_MAP_END) || grid_end;

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    held_next  = held;
    ovf_next   = ovf;
    col_next   = col;
    row_next   = row;
    emit       = 1'b0;
    emit_done  = 1'b0;
    if (fire) begin
      case (phase)
        PH_CELL: begin
          if (tok.is_digit) begin
            acc_next   = TILE_BITS'(tok.digit);
            held_next  = '0;
            ovf_next   = 1'b0;
            phase_next = PH_LAYER;
          end else begin
            if (tok.sep != SEP_MAP_END) begin
              row_next = row_wrap ? '0 : row_inc[CW-1:0];
              col_next = row_wrap ? col_inc[CW-1:0] : col;
            end
            if (cell_done) begin
              emit       = 1'b1;
              emit_done  = 1'b1;
              phase_next = PH_DONE;
            end
          end
        end
        PH_LAYER: begin
          if (tok.is_digit) begin
            acc_next = acc_dig;
            ovf_next = ovf || dig_sat;
          end else begin
            held_next  = layer_val;
            ovf_next   = ovf || layer_sat;
            acc_next   = '0;
            phase_next = PH_TILE;
          end
        end
        PH_TILE: begin
          if (tok.is_digit) begin
            acc_next = acc_dig;
            ovf_next = ovf || dig_sat;
          end else begin
            emit      = 1'b1;
            acc_next  = '0;
            held_next = '0;
            ovf_next  = 1'b0;
            if (tok.sep == SEP_NEXT_ENTRY) begin
              phase_next = PH_LAYER;
            end else begin
              if (tok.sep != SEP_MAP_END) begin
                row_next = row_wrap ? '0 : row_inc[CW-1:0];
                col_next = row_wrap ? col_inc[CW-1:0] : col;
              end
              emit_done  = cell_done;
              phase_next = cell_done ? PH_DONE : PH_CELL;
            end
          end
        end
        default: begin
          // Map finished: every further byte is dropped.
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CELL;
      acc       <= '0;
      held      <= '0;
      ovf       <= 1'b0;
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      acc   <= acc_next;
      held  <= held_next;
      ovf   <= ovf_next;
      col   <= col_next;
      row   <= row_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; a completion without an entry carries zeros.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_has_entry <= (phase == PH_TILE);
      out_map_done  <= emit_done;
      if (phase == PH_TILE) begin
        out_col       <= col;
        out_row       <= row;
        out_layer     <= held;
        out_tile      <= acc;
        out_solid     <= (held == '0);
        out_overflow  <= ovf;
        out_bad_layer <= (LW'(held) > LW'(layer_count));
      end else begin
        out_col       <= '0;
        out_row       <= '0;
        out_layer     <= '0;
        out_tile      <= '0;
        out_solid     <= 1'b0;
        out_overflow  <= 1'b0;
        out_bad_layer <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/tile_map_cell_stream_decoder_core.sv =====
// Top level of the tile map cell stream decoder: register port, front end, queue and back end.
//
//   Channel   Direction  Transfer when            Payload
//   s_axis    in         tvalid && tready         tdata: data_byte
//   m_axis    out        tvalid && tready         tdata: col, row, layer_number, tile_number,
//                                                        solid, overflow, bad_layer
//                                                 tuser: has_entry, map_done
//   cfg       in         cfg_wr_en                cfg_addr selects the register, cfg_wdata
//
// The block takes one byte per cycle while the queue has room. A byte goes through the
// classifier into a four-entry queue in the cycle it is accepted; the back end consumes
// one queued byte per cycle while the result register is free or draining, doing one
// multiply-by-253-and-add; a separator that finishes an entry lands in the result register.
// Reset (rst, synchronous, active high) empties the queue and the result register, sets the
// decoder to the start of cell (0,0) and loads map_width = 1, map_height = 1, layer_count = 0.
// A stall on m_axis holds the result register and fills the queue; s_axis tready drops only
// when the queue is full, so the input side keeps moving while a result waits.
module tile_map_cell_stream_decoder_core
  import tmcsd_pkg::*;
#(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int TILE_BITS  = TILE_BITS_DEF,
  parameter int LAYER_BITS = LAYER_BITS_DEF,
  localparam int CW        = $clog2(MAX_SIDE),
  localparam int OUT_RAW   = 2 * CW + LAYER_BITS + TILE_BITS + 3,
  localparam int OUT_DW    = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  // Input byte stream.
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [BYTE_BITS-1:0]      s_axis_tdata,   // [7:0] data_byte
  // Result stream.
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // From bit 0 up: col, row, layer_number, tile_number, solid, overflow, bad_layer, zero fill.
  output logic [OUT_DW-1:0]         m_axis_tdata,
  output logic [1:0]                m_axis_tuser,   // [0] has_entry, [1] map_done
  // Register write port.
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_addr,
  input  logic [CFG_WIDTH-1:0]      cfg_wdata
);

  // Width used to compare a written size against MAX_SIDE.
  localparam int SW = (CW + 1 > CFG_WIDTH) ? CW + 1 : CFG_WIDTH;

  logic [CW:0]                 side_w;
  logic [CW:0]                 side_h;
  logic [LAYER_COUNT_BITS-1:0] layer_count;
  logic [SW-1:0]               cfg_ext;
  logic [CW:0]                 cfg_side;

  token_t        push_token;
  token_t        head_token;
  logic          push;
  logic          pop;
  queue_status_t q_status;

  logic [CW-1:0]         out_col;
  logic [CW-1:0]         out_row;
  logic [LAYER_BITS-1:0] out_layer;
  logic [TILE_BITS-1:0]  out_tile;
  logic                  out_solid;
  logic                  out_has_entry;
  logic                  out_map_done;
  logic                  out_overflow;
  logic                  out_bad_layer;

  // Sizes are stored already clamped: zero counts as one, anything above MAX_SIDE as
  // MAX_SIDE. The grid walk then only compares against these registers.
  assign cfg_ext = SW'(cfg_wdata);

  always_comb begin
    if (cfg_ext == '0) begin
      cfg_side = (CW + 1)'(1);
    end else if (cfg_ext > SW'(MAX_SIDE)) begin
      cfg_side = (CW + 1)'(MAX_SIDE);
    end else begin
      cfg_side = cfg_ext[CW:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_w      <= (CW + 1)'(1);
      side_h      <= (CW + 1)'(1);
      layer_count <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MAP_WIDTH:   side_w      <= cfg_side;
        REG_MAP_HEIGHT:  side_h      <= cfg_side;
        REG_LAYER_COUNT: layer_count <= cfg_wdata[LAYER_COUNT_BITS-1:0];
        default: begin
          // Unused index: the write is dropped.
        end
      endcase
    end
  end

  tmcsd_front u_front (
    .in_valid   (s_axis_tvalid),
    .in_byte    (s_axis_tdata),
    .in_ready   (s_axis_tready),
    .q_status   (q_status),
    .push       (push),
    .push_token (push_token)
  );

  tmcsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .head_token (head_token),
    .status     (q_status)
  );

  tmcsd_back #(
    .MAX_SIDE   (MAX_SIDE),
    .TILE_BITS  (TILE_BITS),
    .LAYER_BITS (LAYER_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .tok           (head_token),
    .q_status      (q_status),
    .pop           (pop),
    .side_w        (side_w),
    .side_h        (side_h),
    .layer_count   (layer_count),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_layer     (out_layer),
    .out_tile      (out_tile),
    .out_solid     (out_solid),
    .out_has_entry (out_has_entry),
    .out_map_done  (out_map_done),
    .out_overflow  (out_overflow),
    .out_bad_layer (out_bad_layer)
  );

  // Pack the result fields, first field in the lowest bits, zero fill at the top.
  assign m_axis_tdata = OUT_DW'({out_bad_layer, out_overflow, out_solid, out_tile,
                                 out_layer, out_row, out_col});
  assign m_axis_tuser = {out_map_done, out_has_entry};

endmodule

// ===== dv/tmcsd_checker.sv =====
// Checker for the tile map cell stream decoder: tracks transfers, predicts results and compares.
module tmcsd_checker
  import tmcsd_pkg::*;
#(
  parameter int OUT_DW =
    ((2 * $clog2(MAX_SIDE_DEF) + LAYER_BITS_DEF + TILE_BITS_DEF + 3 + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [BYTE_BITS-1:0]      s_axis_tdata,   // [7:0] data_byte
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // From bit 0 up: col, row, layer_number, tile_number, solid, overflow, bad_layer, zero fill.
  input  logic [OUT_DW-1:0]         m_axis_tdata,
  input  logic [1:0]                m_axis_tuser,   // [0] has_entry, [1] map_done
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_addr,
  input  logic [CFG_WIDTH-1:0]      cfg_wdata,
  output int                        failures,
  output int                        pending
);

  localparam int CW        = $clog2(MAX_SIDE_DEF);
  localparam int LW        = LAYER_BITS_DEF;
  localparam int TW        = TILE_BITS_DEF;
  localparam int ROW_LSB   = CW;
  localparam int LAYER_LSB = 2 * CW;
  localparam int TILE_LSB  = 2 * CW + LW;
  localparam int FLAG_LSB  = TILE_LSB + TW;
  localparam int RAW_BITS  = FLAG_LSB + 3;
  localparam longint unsigned TILE_MAX  = (64'd1 << TW) - 1;
  localparam int unsigned     LAYER_MAX = (1 << LW) - 1;

  typedef enum logic [1:0] {AT_CELL_START, IN_LAYER, IN_TILE, MAP_FINISHED} decode_phase_t;

  typedef struct packed {
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    logic [LW-1:0] layer;
    logic [TW-1:0] tile;
    logic          solid;
    logic          has_entry;
    logic          map_done;
    logic          overflow;
    logic          bad_layer;
  } tile_entry_t;

  tile_entry_t expected_entries[$];

  logic [CFG_WIDTH-1:0]        map_w;
  logic [CFG_WIDTH-1:0]        map_h;
  logic [LAYER_COUNT_BITS-1:0] layer_limit;

  decode_phase_t decode_phase;
  int unsigned   number_acc;
  int unsigned   held_layer;
  logic          saturated;
  int unsigned   col_count;
  int unsigned   row_count;

  initial failures = 0;
  initial pending  = 0;

  function automatic int unsigned clamp_side(input logic [CFG_WIDTH-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return 32'(v);
  endfunction

  task automatic open_entry();
    number_acc = 0;
    held_layer = 0;
    saturated  = 1'b0;
  endtask

  task automatic add_digit(input int unsigned d);
    longint unsigned v;
    v = longint'(number_acc) * DIGIT_BASE + d;
    if (v > TILE_MAX) begin
      v = TILE_MAX;
      saturated = 1'b1;
    end
    number_acc = v[31:0];
  endtask

  // Rows are the inner loop; a column finishes when the row count wraps.
  task automatic advance_cell(output logic finished);
    finished = 1'b0;
    row_count++;
    if (row_count >= clamp_side(map_h)) begin
      row_count = 0;
      col_count++;
      if (col_count >= clamp_side(map_w)) finished = 1'b1;
    end
  endtask

  task automatic decode_byte(input logic [BYTE_BITS-1:0] b);
    tile_entry_t r;
    logic        finished;
    r = '0;
    finished = 1'b0;
    case (decode_phase)
      AT_CELL_START: begin
        if (b >= DIGIT_OFFSET) begin
          open_entry();
          number_acc   = b - DIGIT_OFFSET;
          decode_phase = IN_LAYER;
        end else begin
          if (b[1:0] == SEP_MAP_END) finished = 1'b1;
          else advance_cell(finished);
          if (finished) begin
            decode_phase = MAP_FINISHED;
            r.map_done   = 1'b1;
            expected_entries.push_back(r);
          end
        end
      end
      IN_LAYER: begin
        if (b >= DIGIT_OFFSET) begin
          add_digit(b - DIGIT_OFFSET);
        end else begin
          if (number_acc > LAYER_MAX) begin
            held_layer = LAYER_MAX;
            saturated  = 1'b1;
          end else begin
            held_layer = number_acc;
          end
          number_acc   = 0;
          decode_phase = IN_TILE;
        end
      end
      IN_TILE: begin
        if (b >= DIGIT_OFFSET) begin
          add_digit(b - DIGIT_OFFSET);
        end else begin
          r.col       = col_count[CW-1:0];
          r.row       = row_count[CW-1:0];
          r.layer     = held_layer[LW-1:0];
          r.tile      = number_acc[TW-1:0];
          r.solid     = (held_layer == 0);
          r.has_entry = 1'b1;
          r.overflow  = saturated;
          r.bad_layer = (held_layer > layer_limit);
          if (b[1:0] == SEP_NEXT_ENTRY) begin
            decode_phase = IN_LAYER;
          end else begin
            if (b[1:0] == SEP_MAP_END) finished = 1'b1;
            else advance_cell(finished);
            decode_phase = finished ? MAP_FINISHED : AT_CELL_START;
            r.map_done   = finished;
          end
          open_entry();
          expected_entries.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    tile_entry_t want;
    if (rst) begin
      map_w        = CFG_WIDTH'(1);
      map_h        = CFG_WIDTH'(1);
      layer_limit  = '0;
      decode_phase = AT_CELL_START;
      open_entry();
      col_count = 0;
      row_count = 0;
      expected_entries.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_MAP_WIDTH:   map_w = cfg_wdata;
          REG_MAP_HEIGHT:  map_h = cfg_wdata;
          REG_LAYER_COUNT: layer_limit = cfg_wdata[LAYER_COUNT_BITS-1:0];
          default: ;
        endcase
      end
      // A byte passes the queue and the result register before it reaches the output, so
      // results are compared before the byte of this edge is predicted.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_entries.size() == 0) begin
          $error("result transfer with nothing expected: tdata %h tuser %b",
                 m_axis_tdata, m_axis_tuser);
          failures++;
        end else begin
          want = expected_entries.pop_front();
          check_field("col", 64'(want.col), 64'(m_axis_tdata[0 +: CW]));
          check_field("row", 64'(want.row), 64'(m_axis_tdata[ROW_LSB +: CW]));
          check_field("layer_number", 64'(want.layer), 64'(m_axis_tdata[LAYER_LSB +: LW]));
          check_field("tile_number", 64'(want.tile), 64'(m_axis_tdata[TILE_LSB +: TW]));
          check_field("solid", 64'(want.solid), 64'(m_axis_tdata[FLAG_LSB]));
          check_field("overflow", 64'(want.overflow), 64'(m_axis_tdata[FLAG_LSB + 1]));
          check_field("bad_layer", 64'(want.bad_layer), 64'(m_axis_tdata[FLAG_LSB + 2]));
          check_field("tdata fill", 64'd0, 64'(m_axis_tdata >> RAW_BITS));
          check_field("has_entry", 64'(want.has_entry), 64'(m_axis_tuser[0]));
          check_field("map_done", 64'(want.map_done), 64'(m_axis_tuser[1]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
    end
    pending <= expected_entries.size();
  end

endmodule

// ===== dv/tb_tile_map_cell_stream_decoder_core.sv =====
// Testbench top for the tile map cell stream decoder: clock, reset, stimulus and verdict.
module tb_tile_map_cell_stream_decoder_core;
  import tmcsd_pkg::*;

  // The result bus width follows the same rule as the block's default parameters.
  localparam int RESULT_BITS =
    ((2 * $clog2(MAX_SIDE_DEF) + LAYER_BITS_DEF + TILE_BITS_DEF + 3 + 7) / 8) * 8;

  // Bytes below the digit offset are separators; these are their stream values.
  localparam logic [BYTE_BITS-1:0] MAP_END_BYTE    = {6'b0, SEP_MAP_END};
  localparam logic [BYTE_BITS-1:0] NEXT_ENTRY_BYTE = {6'b0, SEP_NEXT_ENTRY};
  localparam logic [BYTE_BITS-1:0] CELL_END_BYTE   = {6'b0, SEP_CELL_END};

  // The long receiver hold must stay well inside the watchdog limit.
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_BYTES = 135;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [BYTE_BITS-1:0]      s_axis_tdata = '0;   // [7:0] data_byte
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // From bit 0 up: col, row, layer_number, tile_number, solid, overflow, bad_layer, zero fill.
  logic [RESULT_BITS-1:0]    m_axis_tdata;
  logic [1:0]                m_axis_tuser;        // [0] has_entry, [1] map_done
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_addr = REG_MAP_WIDTH;
  logic [CFG_WIDTH-1:0]      cfg_wdata = '0;

  int          failures;
  int          pending;
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;

  always #4 clk = ~clk;

  tile_map_cell_stream_decoder_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  tmcsd_checker #(.OUT_DW(RESULT_BITS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .failures      (failures),
    .pending       (pending)
  );

  // The watchdog ends the run when no transfer of any kind happens for too long.
  // Reset cycles and register writes count as activity.
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tile_map_cell_stream_decoder_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [BYTE_BITS-1:0] digit_byte(input int unsigned d);
    return BYTE_BITS'(DIGIT_OFFSET + d);
  endfunction

  // Layer digits lean toward small values so that the layer_count compare sees
  // both outcomes; other digits lean toward the ends of the digit range.
  function automatic int unsigned pick_digit(input logic layer_digit);
    if (layer_digit) begin
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 252) : $urandom_range(0, 12);
    end
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 252;
      default: return $urandom_range(0, 252);
    endcase
  endfunction

  // Offers one byte and waits for its transfer. The sender works in bursts; at
  // the end of a burst it may drop tvalid for a random gap, or run straight on.
  task automatic send_byte(input logic [BYTE_BITS-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 32);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_number(input int unsigned digits, input logic layer_digit);
    int unsigned k;
    for (k = 0; k < digits; k++) send_byte(digit_byte(pick_digit(layer_digit)));
  endtask

  // One well formed cell: empty, or up to three entries. The first entry of a
  // cell must open with a digit, since a separator there would close the cell.
  // Any separator may follow a layer number; only continue and cell end close a tile.
  task automatic send_cell();
    int unsigned          entries;
    int unsigned          k;
    int unsigned          tile_digits;
    logic [BYTE_BITS-1:0] layer_sep;
    entries = $urandom_range(0, 3);
    if (entries == 0) begin
      send_byte($urandom_range(0, 1) ? CELL_END_BYTE : NEXT_ENTRY_BYTE);
    end else begin
      for (k = 0; k < entries; k++) begin
        send_number((k == 0) ? $urandom_range(1, 2) : $urandom_range(0, 2), 1'b1);
        layer_sep = BYTE_BITS'($urandom_range(0, 2));
        send_byte(layer_sep);
        tile_digits = $urandom_range(0, 9);
        tile_digits = (tile_digits == 0) ? 0 : (tile_digits < 6) ? 1 :
                      (tile_digits < 8) ? 2 : (tile_digits == 8) ? 3 : 4;
        send_number(tile_digits, 1'b0);
        send_byte((k + 1 < entries) ? NEXT_ENTRY_BYTE : CELL_END_BYTE);
      end
    end
  endtask

  // A broken sequence: random nonzero bytes that may stop anywhere in an entry.
  // Two cell end bytes bring the decoder back to the start of a cell from any
  // point, so the map cannot end by accident afterwards.
  task automatic send_noise();
    int unsigned count;
    int unsigned k;
    count = $urandom_range(1, 4);
    for (k = 0; k < count; k++) send_byte(BYTE_BITS'($urandom_range(1, 255)));
    send_byte(CELL_END_BYTE);
    send_byte(CELL_END_BYTE);
  endtask

  // Waits until every expected result has arrived, then lets the queue empty
  // of bytes that produce no result.
  task automatic settle(input int unsigned tail);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_WIDTH-1:0] width_v,
                              input logic [CFG_WIDTH-1:0] height_v,
                              input logic [LAYER_COUNT_BITS-1:0] layers_v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_MAP_WIDTH;
    cfg_wdata <= width_v;
    @(posedge clk);
    cfg_addr  <= REG_MAP_HEIGHT;
    cfg_wdata <= height_v;
    @(posedge clk);
    cfg_addr  <= REG_LAYER_COUNT;
    cfg_wdata <= CFG_WIDTH'(layers_v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // The receiver stalls on a pattern of its own: stretches always ready, short
  // stalls and random toggling. Once the random stimulus starts it holds off for
  // a long stretch so that the block fills up and drops s_axis_tready.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned k;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_armed && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        span = (mode == 1) ? $urandom_range(1, 12) : $urandom_range(1, 40);
        for (k = 0; k < span; k++) begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'b0;
            default: m_axis_tready <= 1'($urandom_range(0, 1));
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned          p;
    int unsigned          phase_end;
    int unsigned          way;
    int unsigned          k;
    logic [CFG_WIDTH-1:0] width_v;
    logic [CFG_WIDTH-1:0] height_v;
    logic [7:0]           layers_v;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // The map can finish only once per run, so until the very end the width stays at or above
    // the largest side or the rows cannot wrap, and the counters never wrap the map.
    program_regs(11'd2047, 11'd2047, 8'd0);

    // Directed bytes. Empty cells closed by each of the two non-final separators.
    send_byte(CELL_END_BYTE);
    send_byte(NEXT_ENTRY_BYTE);
    // A solid tile with the largest single digit, its layer closed by the map end
    // separator (legal there), followed by another entry in the same cell.
    send_byte(digit_byte(0));
    send_byte(MAP_END_BYTE);
    send_byte(digit_byte(252));
    send_byte(NEXT_ENTRY_BYTE);
    // That entry has an empty layer and an empty tile number, then the cell ends.
    send_byte(CELL_END_BYTE);
    send_byte(CELL_END_BYTE);
    // Layer and tile numbers that both saturate.
    send_byte(digit_byte(252));
    send_byte(digit_byte(3));
    send_byte(NEXT_ENTRY_BYTE);
    send_number(4, 1'b0);
    send_byte(digit_byte(252));
    send_byte(CELL_END_BYTE);
    // A layer above layer_count with a two digit tile.
    send_byte(digit_byte(4));
    send_byte(CELL_END_BYTE);
    send_byte(digit_byte(0));
    send_byte(digit_byte(1));
    send_byte(CELL_END_BYTE);
    // The largest layer that does not saturate, built from two digits.
    send_byte(digit_byte(1));
    send_byte(digit_byte(2));
    send_byte(MAP_END_BYTE);
    send_byte(digit_byte(1));
    send_byte(CELL_END_BYTE);
    settle(12);

    // Random phases, each with its own register setting. A zero width is safe
    // in the phase with the tallest columns because the row count cannot wrap
    // there; shrinking the height moves counters that are already past it on.
    for (p = 0; p < PHASES; p++) begin
      layers_v = 8'($urandom_range(0, 255));
      case (p)
        0: begin width_v = 11'd2047; height_v = 11'd1; layers_v = 8'd255; end
        1: begin width_v = 11'd0; height_v = 11'd2047; layers_v = 8'd0; end
        2: begin width_v = 11'd1024; height_v = 11'd3; end
        3: begin width_v = 11'd2047; height_v = 11'd1024; layers_v = 8'd255; end
        4: begin
          width_v  = CFG_WIDTH'($urandom_range(1024, 2047));
          height_v = 11'd0;
          layers_v = 8'd0;
        end
        5: begin width_v = 11'd1024; height_v = CFG_WIDTH'($urandom_range(2, 16)); end
        6: begin width_v = 11'd2047; height_v = 11'd2; end
        default: begin
          width_v  = CFG_WIDTH'($urandom_range(1024, 2047));
          height_v = CFG_WIDTH'($urandom_range(1, 1023));
          layers_v = 8'($urandom_range(1, 254));
        end
      endcase
      program_regs(width_v, height_v, layers_v);
      if (p == 0) hold_armed = 1'b1;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_cell();
      end
      settle(12);
    end

    // Finish the map in one of three ways: a map end separator at a cell start,
    // an entry closed by the map end separator, or sizes shrunk below the
    // counters so that the next cell end completes the map.
    way = $urandom_range(0, 2);
    case (way)
      0: send_byte(MAP_END_BYTE);
      1: begin
        send_number($urandom_range(1, 2), 1'b1);
        send_byte(CELL_END_BYTE);
        send_number($urandom_range(0, 3), 1'b0);
        send_byte(MAP_END_BYTE);
      end
      default: begin
        settle(12);
        program_regs(11'd0, 11'd0, LAYER_COUNT_BITS'($urandom_range(0, 255)));
        send_cell();
      end
    endcase

    // Every byte after completion is taken in and ignored.
    for (k = 0; k < 16; k++) send_byte(BYTE_BITS'($urandom_range(0, 255)));
    settle(24);

    if (failures == 0 && pending == 0) begin
      $display("tile_map_cell_stream_decoder_core test passed");
    end else begin
      $display("tile_map_cell_stream_decoder_core test failed");
    end
    $finish;
  end

endmodule
